// ----- hw/rtl/prc_pkg.sv -----
// prc_pkg: field widths, stream word layout and the result record of the page run coalescer
// no dependencies; used by page_run_coalescer_core and tb_page_run_coalescer_core
package prc_pkg;

	localparam int unsigned VA_W     = 64;
	localparam int unsigned PA_W     = 64;
	localparam int unsigned STRIDE_W = 32;
	localparam int unsigned CNT_W    = 32;

	// input word: va_base, page_stride, phys_addr (160 bits, whole bytes)
	localparam int unsigned IN_DATA_W  = VA_W + STRIDE_W + PA_W;
	// output word: run_virt_addr, run_phys_addr, run_pages (160 bits, whole bytes)
	localparam int unsigned OUT_DATA_W = VA_W + PA_W + CNT_W;

	// result buffer depth; one item gives at most two results
	localparam int unsigned OBUF_DEPTH = 2;
	localparam int unsigned OBUF_PTR_W = $clog2(OBUF_DEPTH);
	localparam int unsigned OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

	typedef logic [VA_W-1:0]     va_t;
	typedef logic [PA_W-1:0]     pa_t;
	typedef logic [STRIDE_W-1:0] stride_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef struct packed {
		logic done;
		cnt_t pages;
		pa_t  phys;
		va_t  virt;
	} run_rec_t;

endpackage

// ----- hw/rtl/page_run_coalescer_core.sv -----
// page_run_coalescer_core: merges the pages of a page-table update into contiguous runs
// depends on prc_pkg (widths, word layout, result record)
//
// Each input word is one page of an update event. The word flagged on tuser opens an event
// and brings the virtual base and page size; tlast marks the event's final page. A page whose
// physical address is the previous one plus the page size (modulo 2^64) extends the open run;
// any other address closes the open run, which is sent, and opens a new one. The final page
// sends the last run with tlast set, so one page can send two run words. Pages outside an
// event are dropped, and a new event dropping an unfinished one sends nothing for it.
// Run counts saturate at all ones; virtual addresses keep advancing. In order, a word is
// registered on input, evaluated against the held run state (one 64-bit add and compare,
// one 64-bit add) and written into a two-entry result buffer feeding m_axis. The block
// takes one page per cycle while the result buffer has room, and sends one run word per
// cycle while results wait and m_axis_tready is high; a page that sends two words waits
// until the result buffer is empty. A run word reaches m_axis from the registered buffer.
module page_run_coalescer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata, low bit up: va_base[63:0], page_stride[95:64], phys_addr[159:96]
	input  logic [prc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: first_page
	input  logic                           s_axis_tuser,
	// tlast: last_page
	input  logic                           s_axis_tlast,
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// tdata, low bit up: run_virt_addr[63:0], run_phys_addr[127:64], run_pages[159:128]
	output logic [prc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// tlast: event_done
	output logic                           m_axis_tlast
);

	// input register stage
	logic                   valid_s1;
	logic                   first_s1;
	logic                   last_s1;
	prc_pkg::va_t           va_s1;
	prc_pkg::stride_t       stride_s1;
	prc_pkg::pa_t           phys_s1;

	// held run state
	prc_pkg::va_t           open_virt_q;
	prc_pkg::pa_t           open_phys_q;
	prc_pkg::pa_t           prior_phys_q;
	prc_pkg::va_t           next_virt_q;
	prc_pkg::cnt_t          open_count_q;
	prc_pkg::stride_t       held_stride_q;
	logic                   run_active_q;

	// next run state
	prc_pkg::va_t           open_virt_nx;
	prc_pkg::pa_t           open_phys_nx;
	prc_pkg::va_t           next_virt_nx;
	prc_pkg::cnt_t          open_count_nx;
	prc_pkg::stride_t       stride_nx;
	logic                   run_active_nx;

	// per-word decisions
	logic                   live;
	logic                   contig;
	logic                   brk;
	logic                   emit_done;
	logic [1:0]             n_res;
	prc_pkg::run_rec_t      res0;
	prc_pkg::run_rec_t      res1;
	logic                   consume;

	// result buffer
	prc_pkg::run_rec_t                  obuf_q [prc_pkg::OBUF_DEPTH];
	logic [prc_pkg::OBUF_PTR_W-1:0]     wr_ptr_q;
	logic [prc_pkg::OBUF_PTR_W-1:0]     rd_ptr_q;
	logic [prc_pkg::OBUF_CNT_W-1:0]     obuf_cnt_q;
	logic [prc_pkg::OBUF_CNT_W-1:0]     obuf_free;
	logic                               pop;
	prc_pkg::run_rec_t                  head;

	// input side: the stage frees up whenever its word is evaluated
	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			first_s1  <= s_axis_tuser;
			last_s1   <= s_axis_tlast;
			va_s1     <= s_axis_tdata[prc_pkg::VA_W-1:0];
			stride_s1 <= s_axis_tdata[prc_pkg::VA_W +: prc_pkg::STRIDE_W];
			phys_s1   <= s_axis_tdata[prc_pkg::VA_W + prc_pkg::STRIDE_W +: prc_pkg::PA_W];
		end
	end

	// run evaluation for the word in the input stage
	always_comb begin
		// a word counts only inside an event
		live      = first_s1 || run_active_q;
		// page continues the run when it sits one page above the previous one
		contig    = (phys_s1 == prior_phys_q + prc_pkg::pa_t'(held_stride_q));
		brk       = run_active_q && !first_s1 && !contig;
		emit_done = live && last_s1;
		n_res     = {1'b0, brk} + {1'b0, emit_done};

		open_virt_nx  = open_virt_q;
		open_phys_nx  = open_phys_q;
		open_count_nx = open_count_q;
		stride_nx     = held_stride_q;

		if (first_s1) begin
			stride_nx     = stride_s1;
			open_virt_nx  = va_s1;
			open_phys_nx  = phys_s1;
			open_count_nx = prc_pkg::cnt_t'(1);
		end else if (brk) begin
			open_virt_nx  = next_virt_q;
			open_phys_nx  = phys_s1;
			open_count_nx = prc_pkg::cnt_t'(1);
		end else if (open_count_q != '1) begin
			// saturating page count
			open_count_nx = open_count_q + prc_pkg::cnt_t'(1);
		end

		next_virt_nx  = (first_s1 ? va_s1 : next_virt_q) + prc_pkg::va_t'(stride_nx);
		run_active_nx = live && !last_s1;

		res0.virt  = open_virt_q;
		res0.phys  = open_phys_q;
		res0.pages = open_count_q;
		res0.done  = 1'b0;
		res1.virt  = open_virt_nx;
		res1.phys  = open_phys_nx;
		res1.pages = open_count_nx;
		res1.done  = 1'b1;
		// with a single result, the slot-0 record is whichever run closes
		if (!brk) begin
			res0 = res1;
		end
	end

	// evaluate only when the buffer has room for every result this word sends;
	// free space ignores a same-cycle pop so m_axis_tready never reaches s_axis_tready
	assign obuf_free = prc_pkg::OBUF_CNT_W'(prc_pkg::OBUF_DEPTH) - obuf_cnt_q;
	assign consume   = valid_s1 && (prc_pkg::OBUF_CNT_W'(n_res) <= obuf_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_virt_q   <= '0;
			open_phys_q   <= '0;
			prior_phys_q  <= '0;
			next_virt_q   <= '0;
			open_count_q  <= '0;
			held_stride_q <= '0;
			run_active_q  <= 1'b0;
		end else if (consume && live) begin
			open_virt_q   <= open_virt_nx;
			open_phys_q   <= open_phys_nx;
			prior_phys_q  <= phys_s1;
			next_virt_q   <= next_virt_nx;
			open_count_q  <= open_count_nx;
			held_stride_q <= stride_nx;
			run_active_q  <= run_active_nx;
		end
	end

	// result buffer: two-entry ring, up to two writes per cycle
	always_ff @(posedge clk) begin
		if (consume && (n_res != 2'd0)) begin
			obuf_q[wr_ptr_q] <= res0;
		end
		if (consume && (n_res == 2'd2)) begin
			obuf_q[~wr_ptr_q] <= res1;
		end
	end

	assign pop  = m_axis_tvalid && m_axis_tready;
	assign head = obuf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			obuf_cnt_q <= '0;
		end else begin
			if (consume) begin
				wr_ptr_q <= wr_ptr_q + prc_pkg::OBUF_PTR_W'(n_res[0]);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + prc_pkg::OBUF_PTR_W'(1);
			end
			obuf_cnt_q <= obuf_cnt_q
				+ (consume ? prc_pkg::OBUF_CNT_W'(n_res) : '0)
				- prc_pkg::OBUF_CNT_W'(pop);
		end
	end

	// output side
	assign m_axis_tvalid = (obuf_cnt_q != '0);
	assign m_axis_tdata  = {head.pages, head.phys, head.virt};
	assign m_axis_tlast  = head.done;

`ifndef SYNTHESIS
	// buffer never overfills
	a_obuf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		obuf_cnt_q <= prc_pkg::OBUF_CNT_W'(prc_pkg::OBUF_DEPTH))
		else $error("result buffer overflow");

	// a page sending two runs is only evaluated into an empty buffer
	a_pair_room: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && (n_res == 2'd2)) |-> (obuf_cnt_q == '0))
		else $error("two results written without room");

	// closing page always ends the event
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && last_s1) |=> !run_active_q)
		else $error("run still open after last page");

	// a run is sent with at least one page
	a_pages: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (head.pages != '0))
		else $error("empty run sent");
`endif

endmodule

// ----- tb/tb_page_run_coalescer_core.sv -----
// tb_page_run_coalescer_core: self-checking testbench for the page run coalescer
// depends on prc_pkg and page_run_coalescer_core; a clocked driver and monitor, with an
// in-bench run predictor, check every run word against the expected runs in order
module tb_page_run_coalescer_core;
	import prc_pkg::*;

	// one page word as offered on the input stream
	typedef struct {
		logic    first;
		logic    last;
		va_t     va;
		stride_t stride;
		pa_t     phys;
	} page_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SLOW,
		RX_HOLD
	} rx_mode_t;

	localparam int unsigned N_ITEMS    = 1750;
	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned LONG_HOLD  = 200;
	localparam int unsigned DRAIN_WAIT = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	page_t    page_q[$];	// pages still to be offered
	run_rec_t runs_due[$];	// runs the block still owes, oldest first
	int       err_count = 0;

	// predictor copy of the run state
	va_t     run_va;
	pa_t     run_pa;
	pa_t     last_pa;
	va_t     va_next;
	cnt_t    run_cnt;
	stride_t ev_stride;
	logic    in_event;

	// driver state
	page_t cur_page;
	logic  drv_hold;
	logic  drv_valid;
	int    burst_left = 0;
	int    gap_left = 0;

	// receiver state
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_seg = 0;
	logic     rx_rdy;
	run_rec_t want;

	int idle_cycles = 0;

	page_run_coalescer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),	// va_base, page_stride, phys_addr
		.s_axis_tuser  (s_axis_tuser),	// first_page
		.s_axis_tlast  (s_axis_tlast),	// last_page
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),	// run_virt_addr, run_phys_addr, run_pages
		.m_axis_tlast  (m_axis_tlast)	// event_done
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// page sizes: common sizes, zero, all ones and random ones
	function automatic stride_t pick_stride();
		case ($urandom_range(0, 7))
			0: return 32'd4096;
			1: return 32'd65536;
			2: return 32'd2097152;
			3: return '0;
			4: return '1;
			5: return $urandom;
			6: return $urandom_range(1, 64);
			default: return 32'd1 << $urandom_range(0, 31);
		endcase
	endfunction

	// virtual bases: random, near the top so the run wraps, zero, page aligned
	function automatic va_t pick_va();
		case ($urandom_range(0, 3))
			0: return rand64();
			1: return 64'hFFFF_FFFF_FFFF_F000 - 64'($urandom_range(0, 8192));
			2: return '0;
			default: return {20'h0, $urandom, 12'h0};
		endcase
	endfunction

	task automatic add_page(input logic first, input logic last, input va_t va,
			input stride_t stride, input pa_t phys);
		page_t p;
		p.first  = first;
		p.last   = last;
		p.va     = va;
		p.stride = stride;
		p.phys   = phys;
		page_q.push_back(p);
	endtask

	// one event of n pages, a break about once in brk_odds pages; close sets the last flag
	task automatic add_event(input int n, input int brk_odds, input logic close);
		va_t     va;
		stride_t st;
		pa_t     pa;
		va = pick_va();
		st = pick_stride();
		pa = ($urandom_range(0, 3) == 0) ? pa_t'(64'hFFFF_FFFF_FFFF_FFFF - 64'(st) * 2) : rand64();
		for (int k = 0; k < n; k++) begin
			if (k > 0) begin
				if ($urandom_range(0, brk_odds - 1) == 0) begin
					case ($urandom_range(0, 3))
						0: pa = rand64();
						1: pa = pa + st + 64'd1;
						2: pa = pa;	// repeated page, joins only for a zero page size
						default: pa = pa - st;
					endcase
				end else begin
					pa = pa + st;
				end
			end
			// va and stride are noise on pages after the first
			add_page(k == 0, close && (k == n - 1), (k == 0) ? va : rand64(),
				(k == 0) ? st : stride_t'($urandom), pa);
		end
	endtask

	// works out the runs one accepted page gives and queues them
	task automatic predict_runs(input page_t p);
		run_rec_t r;
		pa_t      step;
		if (p.first) begin
			// a new event drops any unfinished run silently
			ev_stride = p.stride;
			run_va    = p.va;
			run_pa    = p.phys;
			run_cnt   = 1;
			in_event  = 1'b1;
		end else if (!in_event) begin
			return;	// stray page outside an event
		end else begin
			step = p.phys - last_pa;
			if (step == pa_t'(ev_stride)) begin
				if (run_cnt != '1)
					run_cnt = run_cnt + 1;	// saturates at all ones
			end else begin
				r.virt  = run_va;
				r.phys  = run_pa;
				r.pages = run_cnt;
				r.done  = 1'b0;
				runs_due.push_back(r);
				run_va  = va_next;
				run_pa  = p.phys;
				run_cnt = 1;
			end
		end
		last_pa = p.phys;
		va_next = (p.first ? p.va : va_next) + va_t'(ev_stride);
		if (p.last) begin
			r.virt  = run_va;
			r.phys  = run_pa;
			r.pages = run_cnt;
			r.done  = 1'b1;
			runs_due.push_back(r);
			in_event = 1'b0;
		end
	endtask

	// driver: bursts of words with random gaps, a word is held until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
			s_axis_tlast  <= 1'b0;
		end else begin
			drv_hold = 1'b0;
			if (s_axis_tvalid && s_axis_tready)
				predict_runs(cur_page);
			else
				drv_hold = s_axis_tvalid;
			if (!drv_hold) begin
				drv_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (page_q.size() > 0) begin
					cur_page  = page_q.pop_front();
					drv_valid = 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
							: $urandom_range(0, 4);
						burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
							: $urandom_range(1, 24);
					end
				end
				s_axis_tvalid <= drv_valid;
				if (drv_valid) begin
					s_axis_tdata <= {cur_page.phys, cur_page.stride, cur_page.va};
					s_axis_tuser <= cur_page.first;
					s_axis_tlast <= cur_page.last;
				end
			end
		end
	end

	// monitor: checks each taken run word, then picks the next ready value
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (runs_due.size() == 0) begin
					$display("%0t unexpected run word: virt %h phys %h pages %h done %b", $time,
						m_axis_tdata[VA_W-1:0], m_axis_tdata[VA_W+:PA_W],
						m_axis_tdata[VA_W+PA_W+:CNT_W], m_axis_tlast);
					err_count++;
				end else begin
					want = runs_due.pop_front();
					if (m_axis_tdata[VA_W-1:0] !== want.virt) begin
						$display("%0t run_virt_addr mismatch: expected %h actual %h", $time,
							want.virt, m_axis_tdata[VA_W-1:0]);
						err_count++;
					end
					if (m_axis_tdata[VA_W+:PA_W] !== want.phys) begin
						$display("%0t run_phys_addr mismatch: expected %h actual %h", $time,
							want.phys, m_axis_tdata[VA_W+:PA_W]);
						err_count++;
					end
					if (m_axis_tdata[VA_W+PA_W+:CNT_W] !== want.pages) begin
						$display("%0t run_pages mismatch: expected %h actual %h", $time,
							want.pages, m_axis_tdata[VA_W+PA_W+:CNT_W]);
						err_count++;
					end
					if (m_axis_tlast !== want.done) begin
						$display("%0t event_done mismatch: expected %b actual %b", $time,
							want.done, m_axis_tlast);
						err_count++;
					end
				end
			end
			// segments of stall patterns; the fourth is one long hold so the block backs up
			if (rx_left == 0) begin
				rx_seg++;
				if (rx_seg == 4) begin
					rx_mode = RX_HOLD;
					rx_left = LONG_HOLD;
				end else begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_left = (rx_mode == RX_HOLD) ? $urandom_range(5, 60)
						: $urandom_range(20, 120);
				end
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN: rx_rdy = 1'b1;
				RX_COIN: rx_rdy = $urandom_range(0, 1);
				RX_SLOW: rx_rdy = (rx_left % 4 == 0);
				default: rx_rdy = 1'b0;
			endcase
			m_axis_tready <= rx_rdy;
		end
	end

	// watchdog: cycles in a row with no word taken on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog: no word moved for %0d cycles", $time, idle_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		in_event  = 1'b0;
		run_va    = '0;
		run_pa    = '0;
		last_pa   = '0;
		va_next   = '0;
		run_cnt   = '0;
		ev_stride = '0;

		// stray pages before any event, with and without the last flag
		add_page(1'b0, 1'b0, rand64(), $urandom, rand64());
		add_page(1'b0, 1'b1, '1, '1, '1);
		// single page event at the top of every field
		add_page(1'b1, 1'b1, '1, '1, '1);
		// single page event at zero
		add_page(1'b1, 1'b1, '0, '0, '0);
		// run wrapping both address spaces, then a break and a last page that joins
		add_page(1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_F000, 32'd4096, 64'hFFFF_FFFF_FFFF_F000);
		add_page(1'b0, 1'b0, '0, '0, 64'h0);
		add_page(1'b0, 1'b0, '1, '1, 64'h1000);
		add_page(1'b0, 1'b0, '0, '0, 64'h5);
		add_page(1'b0, 1'b1, '0, '0, 64'h1005);
		// zero page size: a repeated address joins, any other breaks
		add_page(1'b1, 1'b0, 64'h1234_5678_9ABC_DEF0, '0, 64'h8000_0000_0000_0000);
		add_page(1'b0, 1'b0, '0, '0, 64'h8000_0000_0000_0000);
		add_page(1'b0, 1'b0, '0, '0, 64'h8000_0000_0000_0001);
		add_page(1'b0, 1'b1, '0, '0, 64'h8000_0000_0000_0001);
		// unfinished event dropped by a new one
		add_page(1'b1, 1'b0, 64'h4000, 32'd4096, 64'h10_0000);
		add_page(1'b0, 1'b0, '0, '0, 64'h10_1000);
		add_page(1'b1, 1'b0, 64'h8000, 32'd8192, 64'h20_0000);
		add_page(1'b0, 1'b1, '0, '0, 64'h20_2000);
		// break on the last page gives two runs from one page
		add_page(1'b1, 1'b0, 64'hFFFF_0000, 32'h0001_0000, 64'hABCD_0000);
		add_page(1'b0, 1'b1, '0, '0, 64'h0);
		// largest page size from a zero base, wrapping physical address
		add_page(1'b1, 1'b0, '0, '1, 64'hFFFF_FFFF_0000_0000);
		add_page(1'b0, 1'b0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
		add_page(1'b0, 1'b1, '0, '0, 64'h0000_0000_FFFF_FFFE);
		// a stray page after a finished event
		add_page(1'b0, 1'b1, rand64(), $urandom, rand64());
		// the saturating page count needs 2^32 pages in one run and stays out of reach

		// random part: mostly closed events, some stray pages and abandoned events
		while (page_q.size() < N_ITEMS + 23) begin
			case ($urandom_range(0, 15))
				0: add_page(1'b0, $urandom_range(0, 1), rand64(), $urandom, rand64());
				1: add_event($urandom_range(1, 10), 4, 1'b0);
				default: add_event(($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
					: $urandom_range(1, 12), ($urandom_range(0, 1) == 0) ? 16 : 3, 1'b1);
			endcase
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// all pages taken, then all runs seen, then a drain long enough for stray words
		while (page_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (runs_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
